/* src/eabv_pkg.sv */
// Shared types, constants and helpers for the Euler-angle to basis-vector block.
// No dependencies; imported by every module of the block.
package eabv_pkg;

   localparam int ANGLE_BITS = 16;
   localparam int FRAC_BITS  = 14;
   localparam int OUT_W      = FRAC_BITS + 2;
   localparam int OFS_W      = ANGLE_BITS - 1;
   localparam int PROD_W     = 2 * OUT_W + 1;
   localparam int NUM_TERMS  = 7;
   localparam int FRAC_SHIFT = 30 - FRAC_BITS;

   localparam logic [31:0] ONE30       = 32'd1 << 30;
   localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
   localparam logic [32:0] FRAC_HALF   = (FRAC_BITS < 30) ? (33'd1 << (29 - FRAC_BITS)) : 33'd0;
   localparam logic [ANGLE_BITS-1:0] QUARTER_A = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

   localparam logic [31:0] INV_TERMS [NUM_TERMS] = '{
      32'd178956971, 32'd53687091, 32'd25565282, 32'd14913081,
      32'd9761289, 32'd6882960, 32'd5113056
   };

   typedef struct packed {
      logic signed [OUT_W-1:0] sp;
      logic signed [OUT_W-1:0] cp;
      logic signed [OUT_W-1:0] sy;
      logic signed [OUT_W-1:0] cy;
      logic signed [OUT_W-1:0] sr;
      logic signed [OUT_W-1:0] cr;
   } sines_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] fwd_x;
      logic signed [OUT_W-1:0] fwd_y;
      logic signed [OUT_W-1:0] fwd_z;
      logic signed [OUT_W-1:0] rgt_x;
      logic signed [OUT_W-1:0] rgt_y;
      logic signed [OUT_W-1:0] rgt_z;
      logic signed [OUT_W-1:0] up_x;
      logic signed [OUT_W-1:0] up_y;
      logic signed [OUT_W-1:0] up_z;
   } basis_type;

   // Q1.30 multiply with round half up
   function automatic logic [31:0] m30(input logic [31:0] a, input logic [31:0] b);
      logic [63:0] p;
      p = {32'd0, a} * {32'd0, b} + (64'd1 << 29);
      return p[61:30];
   endfunction

endpackage

/* src/eabv_sine.sv */
// Pipelined quarter-wave sine: odd polynomial in Horner form, one multiply per stage.
// Depends on eabv_pkg.
module eabv_sine import eabv_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  logic [OFS_W-1:0]        in_offset,
   input  logic                    in_neg,
   output logic                    out_valid,
   output logic signed [OUT_W-1:0] out_value
);

   localparam int LAST = 2 * NUM_TERMS + 1;

   logic        v_ff    [LAST+1];
   logic [31:0] u_ff    [LAST+1];
   logic [31:0] w_ff    [LAST+1];
   logic [31:0] b_ff    [LAST+1];
   logic [31:0] p_ff    [LAST+1];
   logic        zero_ff [LAST+1];
   logic        one_ff  [LAST+1];
   logic        neg_ff  [LAST+1];

   logic [31:0] t_in;
   logic [63:0] up_in;
   logic [31:0] s_in;
   logic [32:0] sum_in;
   logic [OUT_W-1:0] mag_in;

   assign t_in  = 32'(in_offset) << (34 - ANGLE_BITS);
   assign up_in = {32'd0, t_in} * {32'd0, HALF_PI_Q30} + 64'h8000_0000;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else begin
         v_ff[0] <= in_valid;
      end
      u_ff[0]    <= up_in[63:32];
      zero_ff[0] <= (in_offset == '0);
      one_ff[0]  <= in_offset[OFS_W-1];
      neg_ff[0]  <= in_neg;
   end

   genvar i;
   generate
      for (i = 1; i <= LAST; i++) begin : g_carry
         always_ff @(posedge clock) begin
            if (reset) begin
               v_ff[i] <= 1'b0;
            end else begin
               v_ff[i] <= v_ff[i-1];
            end
            u_ff[i]    <= u_ff[i-1];
            zero_ff[i] <= zero_ff[i-1];
            one_ff[i]  <= one_ff[i-1];
            neg_ff[i]  <= neg_ff[i-1];
         end
      end
   endgenerate

   always_ff @(posedge clock) begin
      w_ff[1] <= m30(u_ff[0], u_ff[0]);
      b_ff[1] <= ONE30;
   end

   generate
      for (i = 0; i < NUM_TERMS; i++) begin : g_term
         always_ff @(posedge clock) begin
            p_ff[2*i+2] <= m30(w_ff[2*i+1], INV_TERMS[NUM_TERMS-1-i]);
            b_ff[2*i+2] <= b_ff[2*i+1];
            w_ff[2*i+2] <= w_ff[2*i+1];
            b_ff[2*i+3] <= ONE30 - m30(p_ff[2*i+2], b_ff[2*i+2]);
            w_ff[2*i+3] <= w_ff[2*i+2];
         end
      end
   endgenerate

   always_comb begin
      if (zero_ff[LAST]) begin
         s_in = '0;
      end else if (one_ff[LAST]) begin
         s_in = ONE30;
      end else begin
         s_in = m30(u_ff[LAST], b_ff[LAST]);
      end
      sum_in = {1'b0, s_in} + FRAC_HALF;
      mag_in = OUT_W'(sum_in >> FRAC_SHIFT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid <= 1'b0;
      end else begin
         out_valid <= v_ff[LAST];
      end
      out_value <= neg_ff[LAST] ? -signed'(mag_in) : signed'(mag_in);
   end

endmodule

/* src/eabv_front.sv */
// Front end: accepts angles, splits each into quadrant and offset, runs six sine pipes.
// Depends on eabv_pkg and eabv_sine.
module eabv_front import eabv_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  busy,
   input  logic [ANGLE_BITS-1:0] pitch,
   input  logic [ANGLE_BITS-1:0] yaw,
   input  logic [ANGLE_BITS-1:0] roll,
   output logic                  out_valid,
   output sines_type             out_sines
);

   logic                  accept_in;
   logic [ANGLE_BITS-1:0] ang_in [6];
   logic                  val    [6];
   logic signed [OUT_W-1:0] res  [6];

   function automatic logic [OFS_W:0] classify(input logic [ANGLE_BITS-1:0] a);
      logic [OFS_W-1:0] r;
      logic [OFS_W-1:0] off;
      r   = OFS_W'(a[ANGLE_BITS-3:0]);
      off = a[ANGLE_BITS-2] ? OFS_W'(QUARTER_A) - r : r;
      return {a[ANGLE_BITS-1], off};
   endfunction

   assign accept_in = start & ~busy;
   assign ang_in[0] = pitch;
   assign ang_in[1] = pitch + QUARTER_A;
   assign ang_in[2] = yaw;
   assign ang_in[3] = yaw + QUARTER_A;
   assign ang_in[4] = roll;
   assign ang_in[5] = roll + QUARTER_A;

   genvar i;
   generate
      for (i = 0; i < 6; i++) begin : g_sine
         logic [OFS_W:0] cls;
         assign cls = classify(ang_in[i]);
         eabv_sine u_sine (
            .clock     (clock),
            .reset     (reset),
            .in_valid  (accept_in),
            .in_offset (cls[OFS_W-1:0]),
            .in_neg    (cls[OFS_W]),
            .out_valid (val[i]),
            .out_value (res[i])
         );
      end
   endgenerate

   assign out_valid    = val[0] & val[1] & val[2] & val[3] & val[4] & val[5];
   assign out_sines.sp = res[0];
   assign out_sines.cp = res[1];
   assign out_sines.sy = res[2];
   assign out_sines.cy = res[3];
   assign out_sines.sr = res[4];
   assign out_sines.cr = res[5];

endmodule

/* src/eabv_queue.sv */
// Two-beat queue between the sine front end and the combiner.
// Depends on eabv_pkg.
module eabv_queue import eabv_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  sines_type push_data,
   output logic      pop,
   output sines_type pop_data,
   output logic      full
);

   sines_type  mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;

   assign pop      = (cnt_ff != 2'd0);
   assign pop_data = mem_ff[rd_ptr_ff];
   assign full     = (cnt_ff == 2'd2);

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* src/eabv_back.sv */
// Back end: products of sines and cosines, rounding, clamping, optional right negation.
// Depends on eabv_pkg.
module eabv_back import eabv_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   input  sines_type in_sines,
   input  logic      negate_right,
   output logic      out_valid,
   output basis_type out_basis
);

   localparam int RW = PROD_W - FRAC_BITS;
   localparam logic signed [PROD_W-1:0] HALF_LSB = PROD_W'(1) << (FRAC_BITS - 1);
   localparam logic signed [RW-1:0]     ONE_R    = RW'(1) << FRAC_BITS;

   typedef logic signed [PROD_W-1:0] prod_type;

   function automatic prod_type mul(input logic signed [OUT_W-1:0] a,
                                    input logic signed [OUT_W-1:0] b);
      return PROD_W'(a) * PROD_W'(b);
   endfunction

   function automatic logic signed [RW-1:0] rnd(input prod_type v);
      prod_type x;
      x = v + HALF_LSB;
      return RW'(x >>> FRAC_BITS);
   endfunction

   function automatic logic signed [OUT_W-1:0] clamp(input logic signed [RW-1:0] v);
      logic signed [RW-1:0] c;
      c = v;
      if (v > ONE_R) begin
         c = ONE_R;
      end else if (v < -ONE_R) begin
         c = -ONE_R;
      end
      return OUT_W'(c);
   endfunction

   logic      v0_ff, v1_ff, v2_ff;
   sines_type s0_ff, s1_ff;
   prod_type  ssp_ff, csp_ff;
   logic signed [OUT_W-1:0] srsp_ff, crsp_ff, fz_ff;
   prod_type  cpcy_ff, cpsy_ff, srcp_ff, crcp_ff;
   prod_type  srspcy_ff, crsy_ff, srspsy_ff, crcy_ff;
   prod_type  crspcy_ff, srsy_ff, crspsy_ff, srcy_ff;
   logic signed [OUT_W-1:0] rx_in, ry_in, rz_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v0_ff <= in_valid;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
      end
      s0_ff   <= in_sines;
      ssp_ff  <= mul(in_sines.sr, in_sines.sp);
      csp_ff  <= mul(in_sines.cr, in_sines.sp);
      s1_ff   <= s0_ff;
      srsp_ff <= OUT_W'(rnd(ssp_ff));
      crsp_ff <= OUT_W'(rnd(csp_ff));
      fz_ff     <= -s1_ff.sp;
      cpcy_ff   <= mul(s1_ff.cp, s1_ff.cy);
      cpsy_ff   <= mul(s1_ff.cp, s1_ff.sy);
      srcp_ff   <= mul(s1_ff.sr, s1_ff.cp);
      crcp_ff   <= mul(s1_ff.cr, s1_ff.cp);
      srspcy_ff <= mul(srsp_ff, s1_ff.cy);
      crsy_ff   <= mul(s1_ff.cr, s1_ff.sy);
      srspsy_ff <= mul(srsp_ff, s1_ff.sy);
      crcy_ff   <= mul(s1_ff.cr, s1_ff.cy);
      crspcy_ff <= mul(crsp_ff, s1_ff.cy);
      srsy_ff   <= mul(s1_ff.sr, s1_ff.sy);
      crspsy_ff <= mul(crsp_ff, s1_ff.sy);
      srcy_ff   <= mul(s1_ff.sr, s1_ff.cy);
   end

   always_comb begin
      rx_in = clamp(rnd(crsy_ff - srspcy_ff));
      ry_in = clamp(rnd(-srspsy_ff - crcy_ff));
      rz_in = clamp(rnd(-srcp_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid <= 1'b0;
      end else begin
         out_valid <= v2_ff;
      end
      out_basis.fwd_x <= clamp(rnd(cpcy_ff));
      out_basis.fwd_y <= clamp(rnd(cpsy_ff));
      out_basis.fwd_z <= fz_ff;
      out_basis.rgt_x <= negate_right ? -rx_in : rx_in;
      out_basis.rgt_y <= negate_right ? -ry_in : ry_in;
      out_basis.rgt_z <= negate_right ? -rz_in : rz_in;
      out_basis.up_x  <= clamp(rnd(crspcy_ff + srsy_ff));
      out_basis.up_y  <= clamp(rnd(crspsy_ff - srcy_ff));
      out_basis.up_z  <= clamp(rnd(crcp_ff));
   end

endmodule

/* src/euler_angles_to_basis_vectors.sv */
// Euler angles to basis vectors, top level: control register port, front end, queue, back end.
// Depends on eabv_pkg, eabv_front, eabv_queue and eabv_back.
// One beat of pitch, yaw and roll is taken every cycle that start is high and busy is low; busy
// stays low in normal use. Each beat gives one result beat on rsp_valid after it passes
// through the sine pipelines (one multiply per stage through the polynomial), the two-beat
// queue and the four-stage combiner. Results cannot be held off, so take them as they come.
// Write negate_right only while no beat is in flight.
module euler_angles_to_basis_vectors import eabv_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [ANGLE_BITS-1:0]   req_pitch_angle,
   input  logic [ANGLE_BITS-1:0]   req_yaw_angle,
   input  logic [ANGLE_BITS-1:0]   req_roll_angle,
   output logic                    rsp_valid,
   output logic signed [OUT_W-1:0] rsp_fwd_x,
   output logic signed [OUT_W-1:0] rsp_fwd_y,
   output logic signed [OUT_W-1:0] rsp_fwd_z,
   output logic signed [OUT_W-1:0] rsp_rgt_x,
   output logic signed [OUT_W-1:0] rsp_rgt_y,
   output logic signed [OUT_W-1:0] rsp_rgt_z,
   output logic signed [OUT_W-1:0] rsp_up_x,
   output logic signed [OUT_W-1:0] rsp_up_y,
   output logic signed [OUT_W-1:0] rsp_up_z,
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [2:0]              paddr,
   input  logic [31:0]             pwdata,
   output logic [31:0]             prdata,
   output logic                    pready
);

   localparam logic signed [OUT_W-1:0] ONE_Q = OUT_W'(1) << FRAC_BITS;

   logic      negate_right_ff;
   logic      front_valid;
   sines_type front_sines;
   logic      q_pop;
   sines_type q_data;
   basis_type basis;

   assign pready = 1'b1;
   assign prdata = (paddr[2] == 1'b0) ? {31'd0, negate_right_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         negate_right_ff <= 1'b0;
      end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
         negate_right_ff <= pwdata[0];
      end
   end

   eabv_front u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .pitch     (req_pitch_angle),
      .yaw       (req_yaw_angle),
      .roll      (req_roll_angle),
      .out_valid (front_valid),
      .out_sines (front_sines)
   );

   eabv_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_valid),
      .push_data (front_sines),
      .pop       (q_pop),
      .pop_data  (q_data),
      .full      (busy)
   );

   eabv_back u_back (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (q_pop),
      .in_sines     (q_data),
      .negate_right (negate_right_ff),
      .out_valid    (rsp_valid),
      .out_basis    (basis)
   );

   assign rsp_fwd_x = basis.fwd_x;
   assign rsp_fwd_y = basis.fwd_y;
   assign rsp_fwd_z = basis.fwd_z;
   assign rsp_rgt_x = basis.rgt_x;
   assign rsp_rgt_y = basis.rgt_y;
   assign rsp_rgt_z = basis.rgt_z;
   assign rsp_up_x  = basis.up_x;
   assign rsp_up_y  = basis.up_y;
   assign rsp_up_z  = basis.up_z;

   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("queue filled up");

   a_fwd_x_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_fwd_x <= ONE_Q) && (rsp_fwd_x >= -ONE_Q))
      else $error("fwd_x out of range");

   a_up_z_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_up_z <= ONE_Q) && (rsp_up_z >= -ONE_Q))
      else $error("up_z out of range");

endmodule
